### hdl/alpha_weighted_mipmap_downsample_defines.svh
// Assertion macros shared by the mipmap downsample block.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef ALPHA_WEIGHTED_MIPMAP_DOWNSAMPLE_DEFINES_SVH
`define ALPHA_WEIGHTED_MIPMAP_DOWNSAMPLE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define AWMD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define AWMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/awmd_pkg.sv
// Types and constants for the alpha-weighted mipmap downsample block.
// No dependencies; used by the lane, merge and top-level modules.
package awmd_pkg;

  localparam int NUM_PIX   = 4;   // pixels in one quad
  localparam int NUM_LANES = 3;   // colour channels with their own lane
  localparam int BYTE_W    = 8;
  localparam int PIX_W     = 32;
  localparam int PROD_W    = 2 * BYTE_W;   // colour times alpha
  localparam int ACC_W     = PROD_W + 2;   // sum of four products
  localparam int ASUM_W    = BYTE_W + 2;   // sum of four bytes
  localparam int QUOT_W    = BYTE_W;       // weighted average fits a byte
  localparam int DIV_FIRST = 2;            // first divider stage
  localparam int NSTAGE    = DIV_FIRST + QUOT_W;

  typedef enum logic [1:0] {
    MODE_RGBA  = 2'd0,
    MODE_LA    = 2'd1,
    MODE_LUM   = 2'd2,
    MODE_ALPHA = 2'd3
  } mode_t;

endpackage

### hdl/awmd_lane.sv
// One colour lane: alpha-weighted sum and restoring divide, one quotient bit per stage.
// Depends on awmd_pkg; stage enables come from the top-level pipeline control.
module awmd_lane (
  input  logic                                           clk,
  input  logic [awmd_pkg::NSTAGE-1:0]                    en,
  input  logic [awmd_pkg::NUM_PIX-1:0][awmd_pkg::BYTE_W-1:0] colour,
  input  logic [awmd_pkg::NUM_PIX-1:0][awmd_pkg::BYTE_W-1:0] alpha,
  input  logic [awmd_pkg::ASUM_W-1:0]                    asum,
  output logic [awmd_pkg::QUOT_W-1:0]                    quot
);
  import awmd_pkg::*;

  logic [PROD_W-1:0] prod [NUM_PIX];
  logic [ASUM_W-1:0] dsor [NSTAGE-1];
  logic [ACC_W-1:0]  rem  [QUOT_W+1];
  logic [QUOT_W-1:0] quo  [QUOT_W];

  // Stage 0: four colour-by-alpha products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NUM_PIX; k++) begin
        prod[k] <= colour[k] * alpha[k];
      end
      dsor[0] <= asum;
    end
  end

  // Stage 1: sum of the products is the dividend
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem[0]  <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]) + ACC_W'(prod[3]);
      dsor[1] <= dsor[0];
    end
  end

  // Divider stages, most significant quotient bit first
  for (genvar j = 0; j < QUOT_W; j++) begin : g_step
    localparam int BIT = QUOT_W - 1 - j;
    logic [ACC_W:0]    shifted;
    logic [ACC_W:0]    trial;
    logic [QUOT_W-1:0] quo_prev;

    assign shifted  = (ACC_W + 1)'(dsor[1 + j]) << BIT;
    assign trial    = {1'b0, rem[j]} - shifted;
    if (j == 0) begin : g_first
      assign quo_prev = '0;
    end else begin : g_rest
      assign quo_prev = quo[j - 1];
    end

    always_ff @(posedge clk) begin
      if (en[DIV_FIRST + j]) begin
        if (!trial[ACC_W]) begin
          rem[j + 1] <= trial[ACC_W-1:0];
          quo[j]     <= quo_prev | (QUOT_W'(1) << BIT);
        end else begin
          rem[j + 1] <= rem[j];
          quo[j]     <= quo_prev;
        end
      end
    end

    if (j < QUOT_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en[DIV_FIRST + j]) begin
          dsor[2 + j] <= dsor[1 + j];
        end
      end
    end
  end

  assign quot = quo[QUOT_W-1];

endmodule

### hdl/awmd_merge.sv
// Merge of lane quotients, alpha sum and plain average into one output pixel.
// Depends on awmd_pkg for the mode codes and widths.
module awmd_merge (
  input  awmd_pkg::mode_t                                   mode,
  input  logic [awmd_pkg::ASUM_W-1:0]                       asum,
  input  logic [awmd_pkg::BYTE_W-1:0]                       avg,
  input  logic [awmd_pkg::NUM_LANES-1:0][awmd_pkg::QUOT_W-1:0] quot,
  output logic [awmd_pkg::PIX_W-1:0]                        pixel
);
  import awmd_pkg::*;

  logic [BYTE_W-1:0] alpha_out;

  assign alpha_out = asum[ASUM_W-1:2];

  // Pick the bytes the mode uses; in RGBA and LA modes a zero alpha sum clears the pixel
  always_comb begin
    pixel = '0;
    case (mode)
      MODE_RGBA: begin
        if (asum != '0) begin
          pixel = {alpha_out, quot[2], quot[1], quot[0]};
        end
      end
      MODE_LA: begin
        if (asum != '0) begin
          pixel = {16'h0000, alpha_out, quot[0]};
        end
      end
      MODE_LUM, MODE_ALPHA: begin
        pixel = {24'h000000, avg};
      end
      default: pixel = '0;
    endcase
  end

endmodule

### hdl/alpha_weighted_mipmap_downsample.sv
// Top level of the alpha-weighted 2x2 mipmap downsample filter.
// Depends on awmd_pkg, awmd_lane, awmd_merge and the assertion macro header.

// Takes one 2x2 quad per beat and returns one half-resolution pixel per beat. A
// new quad is accepted every cycle unless every stage and the output are full
// with the output stalled; each quad passes, from acceptance to its result
// appearing on the output, through the colour-by-alpha multiplies, the product
// sum, the restoring divider (one quotient bit per stage) and the output register.
// Three colour lanes run side by side and a merge stage assembles the pixel by
// channel_mode. Stalls on the output fill any bubbles before input is held off.
`include "alpha_weighted_mipmap_downsample_defines.svh"

module alpha_weighted_mipmap_downsample (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: channel_mode
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_wdata,
  // input quad
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] pixel_top_left, [63:32] pixel_top_right,
  // [95:64] pixel_bottom_left, [127:96] pixel_bottom_right
  input  logic [4*awmd_pkg::PIX_W-1:0]   s_axis_tdata,
  // output pixel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] pixel_out
  output logic [awmd_pkg::PIX_W-1:0]     m_axis_tdata
);
  import awmd_pkg::*;

  localparam int LAST = NSTAGE - 1;

  mode_t                                channel_mode;
  logic [NUM_PIX-1:0][PIX_W-1:0]        px;
  logic [NUM_PIX-1:0][BYTE_W-1:0]       alpha_bytes;
  logic [ASUM_W-1:0]                    asum_in;
  logic [ASUM_W-1:0]                    lum_sum;
  logic [NSTAGE-1:0]                    valid;
  logic [NSTAGE:0]                      ready;
  logic [NSTAGE-1:0]                    en;
  mode_t                                mode_p [NSTAGE];
  logic [ASUM_W-1:0]                    asum_p [NSTAGE];
  logic [BYTE_W-1:0]                    avg_p  [NSTAGE];
  logic [NUM_LANES-1:0][QUOT_W-1:0]     quot;
  logic [PIX_W-1:0]                     pixel_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mode <= MODE_RGBA;
    end else if (cfg_we) begin
      channel_mode <= mode_t'(cfg_wdata);
    end
  end

  // Input unpacking, alpha selection and the two byte sums
  assign px = s_axis_tdata;

  always_comb begin
    for (int k = 0; k < NUM_PIX; k++) begin
      alpha_bytes[k] = (channel_mode == MODE_LA) ? px[k][15:8] : px[k][31:24];
    end
    asum_in = ASUM_W'(alpha_bytes[0]) + ASUM_W'(alpha_bytes[1])
            + ASUM_W'(alpha_bytes[2]) + ASUM_W'(alpha_bytes[3]);
    lum_sum = ASUM_W'(px[0][7:0]) + ASUM_W'(px[1][7:0])
            + ASUM_W'(px[2][7:0]) + ASUM_W'(px[3][7:0]);
  end

  // Per-stage ready: a stage can take a beat if empty or its successor moves
  always_comb begin
    ready[NSTAGE] = !m_axis_tvalid || m_axis_tready;
    for (int s = NSTAGE - 1; s >= 0; s--) begin
      ready[s] = !valid[s] || ready[s + 1];
    end
    en[0] = ready[0] && s_axis_tvalid;
    for (int s = 1; s < NSTAGE; s++) begin
      en[s] = ready[s] && valid[s - 1];
    end
  end

  assign s_axis_tready = ready[0];

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NSTAGE; s++) begin
        if (ready[s]) begin
          valid[s] <= valid[s - 1];
        end
      end
    end
  end

  // Sideband carried alongside the lanes
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode_p[0] <= channel_mode;
      asum_p[0] <= asum_in;
      avg_p[0]  <= lum_sum[ASUM_W-1:2];
    end
    for (int s = 1; s < NSTAGE; s++) begin
      if (en[s]) begin
        mode_p[s] <= mode_p[s - 1];
        asum_p[s] <= asum_p[s - 1];
        avg_p[s]  <= avg_p[s - 1];
      end
    end
  end

  // Colour lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [NUM_PIX-1:0][BYTE_W-1:0] colour;

    always_comb begin
      for (int k = 0; k < NUM_PIX; k++) begin
        colour[k] = px[k][BYTE_W*l +: BYTE_W];
      end
    end

    awmd_lane u_lane (
      .clk    (clk),
      .en     (en),
      .colour (colour),
      .alpha  (alpha_bytes),
      .asum   (asum_in),
      .quot   (quot[l])
    );
  end

  awmd_merge u_merge (
    .mode  (mode_p[LAST]),
    .asum  (asum_p[LAST]),
    .avg   (avg_p[LAST]),
    .quot  (quot),
    .pixel (pixel_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ready[NSTAGE]) begin
      m_axis_tvalid <= valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[NSTAGE] && valid[LAST]) begin
      m_axis_tdata <= pixel_next;
    end
  end

  // Input is held off only when every stage and the output are full and the output is stalled
  `AWMD_ASSERT_SAME(a_stall_only_when_full, !s_axis_tready,
    (&valid) && m_axis_tvalid && !m_axis_tready, "input stalled with room in pipeline")
  // An accepted quad occupies the first stage next cycle
  `AWMD_ASSERT_NEXT(a_accept_fills_first, s_axis_tvalid && s_axis_tready,
    valid[0], "accepted beat lost at first stage")
  // A finished quad moves into the output register when it is free
  `AWMD_ASSERT_NEXT(a_last_to_output, valid[LAST] && ready[NSTAGE],
    m_axis_tvalid, "finished beat lost before output")

endmodule
